@@ rtl/e2q_pkg.sv @@
// Package for the Euler-to-quaternion unit: widths, CORDIC constants,
// arctangent table and rotation-order sign table. No dependencies.
package e2q_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int RESULT_BITS = 16;
    localparam int TRIG_STEPS  = 14;
    localparam int QF          = 30;
    localparam int FA          = ANGLE_BITS - 3;
    localparam int FR          = RESULT_BITS - 2;
    localparam int WB          = 34;

    typedef logic signed [WB-1:0] q_t;

    localparam q_t CORDIC_GAIN = 34'sh026DD3B6A;
    localparam q_t HALF_PI     = 34'sh06487ED51;
    localparam q_t PI_Q        = 34'sh0C90FDAA2;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0, ORD_YXZ = 3'd1, ORD_ZXY = 3'd2,
        ORD_ZYX = 3'd3, ORD_YZX = 3'd4, ORD_XZY = 3'd5
    } order_t;

    typedef struct packed {
        q_t x;
        q_t y;
        q_t z;
    } cordic_t;

    function automatic q_t atan_val(input int i);
        logic [31:0] tab [30];
        tab = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
                32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
                32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
                32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
                32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
                32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
                32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
                32'h00000004, 32'h00000002};
        return q_t'({2'b00, tab[i]});
    endfunction

    // sign bit set means subtract the second product; order x, y, z, w
    function automatic logic [3:0] order_neg(input logic [2:0] ord);
        logic [3:0] r;
        case (ord)
            ORD_YXZ: r = 4'b0110;
            ORD_ZXY: r = 4'b1001;
            ORD_ZYX: r = 4'b1010;
            ORD_YZX: r = 4'b0011;
            ORD_XZY: r = 4'b1100;
            default: r = 4'b0101;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/e2q_cell.sv @@
// One CORDIC rotation cell for three angles: a fixed step index, one register stage.
// Depends on e2q_pkg.
module e2q_cell
    import e2q_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [4:0]   step,
    input  logic         vld_in,
    input  cordic_t      d_in  [3],
    input  logic [2:0]   neg_in,
    input  logic [2:0]   ord_in,
    output logic         vld_out,
    output cordic_t      d_out [3],
    output logic [2:0]   neg_out,
    output logic [2:0]   ord_out
);
    cordic_t d_next [3];
    cordic_t d_reg  [3];
    logic    vld_reg;
    logic [2:0] neg_reg;
    logic [2:0] ord_reg;
    q_t      at;

    assign at = atan_val(int'(step));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!d_in[k].z[WB-1])
            begin
                d_next[k].x = d_in[k].x - (d_in[k].y >>> step);
                d_next[k].y = d_in[k].y + (d_in[k].x >>> step);
                d_next[k].z = d_in[k].z - at;
            end
            else
            begin
                d_next[k].x = d_in[k].x + (d_in[k].y >>> step);
                d_next[k].y = d_in[k].y - (d_in[k].x >>> step);
                d_next[k].z = d_in[k].z + at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        neg_reg <= neg_in;
        ord_reg <= ord_in;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;
    assign neg_out = neg_reg;
    assign ord_out = ord_reg;
endmodule

@@ rtl/e2q_combine.sv @@
// Triple products, order signs, rounding and saturation: three register stages.
// Depends on e2q_pkg.
module e2q_combine
    import e2q_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    vld_in,
    input  q_t                      c_in [3],
    input  q_t                      s_in [3],
    input  logic [2:0]              ord_in,
    output logic                    vld_out,
    output logic [RESULT_BITS-1:0]  q_out [4]
);
    localparam int SH = QF - FR;

    logic        v1_reg, v2_reg, v3_reg;
    q_t          ab_reg [8];
    q_t          c_reg  [8];
    logic [3:0]  n1_reg, n2_reg;
    q_t          p_reg  [8];
    logic [RESULT_BITS-1:0] q_reg [4];
    q_t          ab_next [8];
    q_t          p_next  [8];
    logic [RESULT_BITS-1:0] q_next [4];
    logic signed [2*WB-1:0] m1 [8];
    logic signed [2*WB-1:0] m2 [8];
    q_t          sel_a [8];
    q_t          sel_b [8];
    q_t          sel_c [8];
    logic signed [WB+1:0] sum [4];
    logic signed [WB+1:0] rnd [4];
    logic signed [WB+1:0] lim;

    // a0 s1c2c3 b0 c1s2s3; a1 c1s2c3 b1 s1c2s3; a2 c1c2s3 b2 s1s2c3; a3 c1c2c3 b3 s1s2s3
    always_comb
    begin
        sel_a[0] = s_in[0]; sel_b[0] = c_in[1]; sel_c[0] = c_in[2];
        sel_a[1] = c_in[0]; sel_b[1] = s_in[1]; sel_c[1] = s_in[2];
        sel_a[2] = c_in[0]; sel_b[2] = s_in[1]; sel_c[2] = c_in[2];
        sel_a[3] = s_in[0]; sel_b[3] = c_in[1]; sel_c[3] = s_in[2];
        sel_a[4] = c_in[0]; sel_b[4] = c_in[1]; sel_c[4] = s_in[2];
        sel_a[5] = s_in[0]; sel_b[5] = s_in[1]; sel_c[5] = c_in[2];
        sel_a[6] = c_in[0]; sel_b[6] = c_in[1]; sel_c[6] = c_in[2];
        sel_a[7] = s_in[0]; sel_b[7] = s_in[1]; sel_c[7] = s_in[2];
        for (int k = 0; k < 8; k++)
        begin
            m1[k]      = sel_a[k] * sel_b[k];
            ab_next[k] = q_t'(m1[k] >>> QF);
            m2[k]      = ab_reg[k] * c_reg[k];
            p_next[k]  = q_t'(m2[k] >>> QF);
        end
        lim = (WB+2)'(1) <<< FR;
        for (int k = 0; k < 4; k++)
        begin
            if (n2_reg[3-k])
                sum[k] = (WB+2)'(p_reg[2*k]) - (WB+2)'(p_reg[2*k+1]);
            else
                sum[k] = (WB+2)'(p_reg[2*k]) + (WB+2)'(p_reg[2*k+1]);
            if (SH > 0)
                rnd[k] = (sum[k] + ((WB+2)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
            else
                rnd[k] = sum[k];
            if (rnd[k] > lim)
                q_next[k] = lim[RESULT_BITS-1:0];
            else if (rnd[k] < -lim)
                q_next[k] = RESULT_BITS'(-lim);
            else
                q_next[k] = rnd[k][RESULT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ab_reg <= ab_next;
        c_reg  <= sel_c;
        n1_reg <= order_neg(ord_in);
        p_reg  <= p_next;
        n2_reg <= n1_reg;
        q_reg  <= q_next;
    end

    assign vld_out = v3_reg;
    assign q_out   = q_reg;
endmodule

@@ rtl/euler_to_quaternion_unit.sv @@
// Top level of the Euler-to-quaternion unit: angle fold, chain of CORDIC cells,
// product and output stage. Depends on e2q_pkg, e2q_cell, e2q_combine.
//
// Usage: drive angle_first/second/third and pulse start; busy is always low,
// so an item is taken every cycle start is high. The beat is one cycle.
// rotation_order_we with rotation_order_wdata writes the order register
// (0 XYZ .. 5 XZY; 6 and 7 act as XYZ); write it while no item is in flight.
// Pipeline: 1 fold stage, TRIG_STEPS cell stages, 3 product/output stages.
// Throughput: one item per cycle, set by the fully pipelined cell chain.
// done is high for one cycle with quat_x/y/z/w; the receiver cannot stall
// and must take the beat in that cycle.
// Reset clears all valid flags and sets the order to XYZ; items in flight
// are dropped.
module euler_to_quaternion_unit
    import e2q_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ANGLE_BITS-1:0]  angle_first,
    input  logic signed [ANGLE_BITS-1:0]  angle_second,
    input  logic signed [ANGLE_BITS-1:0]  angle_third,
    input  logic                          rotation_order_we,
    input  logic [2:0]                    rotation_order_wdata,
    output logic                          done,
    output logic signed [RESULT_BITS-1:0] quat_x,
    output logic signed [RESULT_BITS-1:0] quat_y,
    output logic signed [RESULT_BITS-1:0] quat_z,
    output logic signed [RESULT_BITS-1:0] quat_w
);
    logic [2:0] order_reg;
    logic       f_vld_reg;
    cordic_t    f_reg  [3];
    cordic_t    f_next [3];
    logic [2:0] fn_reg, fn_next;
    logic [2:0] fo_reg;
    q_t         h [3];
    logic signed [ANGLE_BITS-1:0] ang [3];

    logic       c_vld [TRIG_STEPS+1];
    cordic_t    c_d   [TRIG_STEPS+1][3];
    logic [2:0] c_neg [TRIG_STEPS+1];
    logic [2:0] c_ord [TRIG_STEPS+1];

    q_t         cs [3];
    q_t         sn [3];
    logic [RESULT_BITS-1:0] q [4];

    assign busy = 1'b0;
    assign ang[0] = angle_first;
    assign ang[1] = angle_second;
    assign ang[2] = angle_third;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h[k] = q_t'(ang[k]) <<< (29 - FA);
            fn_next[k] = 1'b0;
            if (h[k] > HALF_PI)
            begin
                h[k] = h[k] - PI_Q;
                fn_next[k] = 1'b1;
            end
            else if (h[k] < -HALF_PI)
            begin
                h[k] = h[k] + PI_Q;
                fn_next[k] = 1'b1;
            end
            f_next[k].x = CORDIC_GAIN;
            f_next[k].y = '0;
            f_next[k].z = h[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORD_XYZ;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            if (rotation_order_we)
                order_reg <= rotation_order_wdata;
            f_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg  <= f_next;
        fn_reg <= fn_next;
        fo_reg <= order_reg;
    end

    assign c_vld[0] = f_vld_reg;
    assign c_d[0]   = f_reg;
    assign c_neg[0] = fn_reg;
    assign c_ord[0] = fo_reg;

    for (genvar i = 0; i < TRIG_STEPS; i++)
    begin : g_cell
        e2q_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (5'(i)),
            .vld_in  (c_vld[i]),
            .d_in    (c_d[i]),
            .neg_in  (c_neg[i]),
            .ord_in  (c_ord[i]),
            .vld_out (c_vld[i+1]),
            .d_out   (c_d[i+1]),
            .neg_out (c_neg[i+1]),
            .ord_out (c_ord[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cs[k] = c_neg[TRIG_STEPS][k] ? -c_d[TRIG_STEPS][k].x : c_d[TRIG_STEPS][k].x;
            sn[k] = c_neg[TRIG_STEPS][k] ? -c_d[TRIG_STEPS][k].y : c_d[TRIG_STEPS][k].y;
        end
    end

    e2q_combine u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (c_vld[TRIG_STEPS]),
        .c_in    (cs),
        .s_in    (sn),
        .ord_in  (c_ord[TRIG_STEPS]),
        .vld_out (done),
        .q_out   (q)
    );

    assign quat_x = q[0];
    assign quat_y = q[1];
    assign quat_z = q[2];
    assign quat_w = q[3];

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> ##(TRIG_STEPS + 3) done)
        else $error("done missing after accepted beat");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TRIG_STEPS + 4))
        else $error("done without a matching start");
    a_sat_x: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat_x <= (1 <<< FR)) && (quat_x >= -(1 <<< FR)))
        else $error("quat_x out of range");
    a_sat_w: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat_w <= (1 <<< FR)) && (quat_w >= -(1 <<< FR)))
        else $error("quat_w out of range");
endmodule

@@ dv/euler_to_quaternion_unit_tb.sv @@
// Self-checking bench for euler_to_quaternion_unit: drives angle triples under every
// rotation order and checks each quaternion against an in-bench fixed-point predictor.
// Depends on e2q_pkg and the unit RTL.
`timescale 1ns / 1ps

module euler_to_quaternion_unit_tb;
    import e2q_pkg::*;

    localparam int STALL_LIMIT = 500;
    localparam int DRAIN_CYCLES = TRIG_STEPS + 10;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [RESULT_BITS-1:0] comp_t;

    typedef struct {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } quat_t;

    class quat_scoreboard;
        quat_t expected_q[$];
        logic [2:0] order;
        int mismatches;
        int checked;
        longint atan_q30[14];

        function new();
            order = 3'd0;
            mismatches = 0;
            checked = 0;
            atan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF};
        endfunction

        function void half_trig(input angle_t a, output longint c, output longint s);
            longint z;
            longint x;
            longint y;
            longint dx;
            longint dy;
            bit flip;
            z = longint'(a) * 65536;
            x = 64'h26DD3B6A;
            y = 0;
            flip = 0;
            if (z > 64'sh6487ED51) begin
                z -= 64'shC90FDAA2;
                flip = 1;
            end
            else if (z < -64'sh6487ED51) begin
                z += 64'shC90FDAA2;
                flip = 1;
            end
            for (int i = 0; i < TRIG_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_q30[i];
                end
                else begin
                    x += dx;
                    y -= dy;
                    z += atan_q30[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint triple(input longint a, input longint b, input longint c);
            return (((a * b) >>> 30) * c) >>> 30;
        endfunction

        function comp_t round_sat(input longint v);
            longint r;
            r = (v + 64'sd32768) >>> 16;
            if (r > 16384)
                r = 16384;
            if (r < -16384)
                r = -16384;
            return comp_t'(r);
        endfunction

        function void note_beat(input angle_t a1, input angle_t a2, input angle_t a3);
            longint c1, s1, c2, s2, c3, s3;
            longint p[4];
            longint q[4];
            bit [3:0] add;
            quat_t e;
            half_trig(a1, c1, s1);
            half_trig(a2, c2, s2);
            half_trig(a3, c3, s3);
            p[0] = triple(s1, c2, c3); q[0] = triple(c1, s2, s3);
            p[1] = triple(c1, s2, c3); q[1] = triple(s1, c2, s3);
            p[2] = triple(c1, c2, s3); q[2] = triple(s1, s2, c3);
            p[3] = triple(c1, c2, c3); q[3] = triple(s1, s2, s3);
            // bits x, y, z, w: set adds the second product
            case (order)
                ORD_YXZ: add = 4'b1001;
                ORD_ZXY: add = 4'b0110;
                ORD_ZYX: add = 4'b0101;
                ORD_YZX: add = 4'b1100;
                ORD_XZY: add = 4'b0011;
                default: add = 4'b1010;
            endcase
            e.x = round_sat(add[3] ? p[0] + q[0] : p[0] - q[0]);
            e.y = round_sat(add[2] ? p[1] + q[1] : p[1] - q[1]);
            e.z = round_sat(add[1] ? p[2] + q[2] : p[2] - q[2]);
            e.w = round_sat(add[0] ? p[3] + q[3] : p[3] - q[3]);
            expected_q.push_back(e);
        endfunction

        function void check_beat(input quat_t got);
            quat_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d z=%0d w=%0d",
                             got.x, got.y, got.z, got.w);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.w !== e.w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quat mismatch order %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             order, e.x, e.y, e.z, e.w, got.x, got.y, got.z, got.w);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    angle_t angle_first;
    angle_t angle_second;
    angle_t angle_third;
    logic rotation_order_we;
    logic [2:0] rotation_order_wdata;
    logic done;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    comp_t quat_w;

    quat_scoreboard sb;
    int stall_cycles;
    int sent;

    euler_to_quaternion_unit u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .angle_first          (angle_first),
        .angle_second         (angle_second),
        .angle_third          (angle_third),
        .rotation_order_we    (rotation_order_we),
        .rotation_order_wdata (rotation_order_wdata),
        .done                 (done),
        .quat_x               (quat_x),
        .quat_y               (quat_y),
        .quat_z               (quat_z),
        .quat_w               (quat_w)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_beat('{quat_x, quat_y, quat_z, quat_w});
        if (rst_n && !((start && !busy) || done))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(input angle_t a1, input angle_t a2, input angle_t a3);
        angle_first <= a1;
        angle_second <= a2;
        angle_third <= a3;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_beat(a1, a2, a3);
        sent++;
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic [2:0] v);
        drain();
        rotation_order_we <= 1'b1;
        rotation_order_wdata <= v;
        @(posedge clk);
        rotation_order_we <= 1'b0;
        sb.order = v;
    endtask

    function automatic angle_t pick_angle();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return angle_t'($urandom_range(0, 51472) - 25736);
        if (sel < 90)
            return angle_t'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'sd25736;
            1: return -16'sd25736;
            2: return 16'sd12868;
            3: return -16'sd12868;
            4: return 16'sh7FFF;
            5: return 16'sh8000;
            6: return 16'sd0;
            default: return angle_t'($urandom_range(25730, 25742));
        endcase
    endfunction

    task automatic random_phase(input int count);
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && n < count; i++) begin
                send_beat(pick_angle(), pick_angle(), pick_angle());
                n++;
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [2:0] orders[9];
        angle_t edges[8];
        orders = '{3'd5, 3'd0, 3'd3, 3'd1, 3'd6, 3'd2, 3'd4, 3'd7, 3'd0};
        edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7FFF, 16'sh8000,
                  16'sd12868, -16'sd12868, 16'sd25737};
        sb = new();
        sent = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        angle_first = '0;
        angle_second = '0;
        angle_third = '0;
        rotation_order_we = 1'b0;
        rotation_order_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 8; i++)
            send_beat(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
        send_beat(16'sd25736, 16'sd25736, 16'sd25736);
        send_beat(-16'sd25736, -16'sd25736, -16'sd25736);
        send_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        hold_off(3);
        for (int k = 0; k < 6; k++) begin
            write_order(orders[k]);
            send_beat(16'sd4000, -16'sd9000, 16'sd20000);
            send_beat(16'sd12868, 16'sd12868, -16'sd12868);
        end

        foreach (orders[k]) begin
            write_order(orders[k]);
            random_phase(200);
        end

        drain();
        $display("%0d angle triples sent, %0d quaternions checked over all 8 order codes",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ euler_to_quaternion_unit.f @@
rtl/e2q_pkg.sv
rtl/e2q_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion_unit.sv
dv/euler_to_quaternion_unit_tb.sv
